// ===== rtl/priority_run_queue_dispatcher_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the run queue dispatcher
// Shared forms for the concurrent checks of the dispatcher ports.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_RUN_QUEUE_DISPATCHER_TOP_MACROS_SVH
`define PRIORITY_RUN_QUEUE_DISPATCHER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRQD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dispatcher check failed");

// Consequent must hold in the cycle after the antecedent.
`define PRQD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dispatcher check failed");

`endif

// ===== rtl/prqd_pkg.sv =====
// ----------------------------------------------------------------------------
// Run queue dispatcher package
// Request and response types, command and status codes, default sizes.
// ----------------------------------------------------------------------------
package prqd_pkg;

    localparam int SLOT_COUNT_DEF  = 64;
    localparam int LEVEL_COUNT_DEF = 6;

    localparam logic [15:0] QUANTUM_RESET = 16'd80;

    localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    localparam logic [2:0] STAT_ENQUEUED   = 3'd0;
    localparam logic [2:0] STAT_DISPATCHED = 3'd1;
    localparam logic [2:0] STAT_NONE_READY = 3'd2;
    localparam logic [2:0] STAT_BAD_PRIO   = 3'd3;
    localparam logic [2:0] STAT_TOO_EARLY  = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  slot;
        logic [2:0]  prio_level;
        logic [31:0] clock_time;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] chosen_slot;
        logic       switched;
    } t_res;

endpackage

// ===== rtl/prqd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/prqd_alu.sv =====
// ----------------------------------------------------------------------------
// Shared subtract unit
// 32-bit difference with borrow and zero flags for compares and elapsed time.
// ----------------------------------------------------------------------------
module prqd_alu (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_diff,
    output logic        o_borrow,
    output logic        o_zero
);

    logic [32:0] diff_ext;

    assign diff_ext = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = diff_ext[31:0];
    assign o_borrow = diff_ext[32];
    assign o_zero   = (diff_ext[31:0] == 32'd0);

endmodule

// ===== rtl/priority_run_queue_dispatcher_top.sv =====
// ----------------------------------------------------------------------------
// Strict priority run queue dispatcher
// Each request is decoded; enqueue then links and clears, dispatch selects,
// reads, updates and compares, and a tick dispatches once the elapsed time has
// reached the quantum. Bad priority, early ticks and empty dispatches end early.
// One request at a time; a held response stalls the sequencer's final step.
// Synchronous active-low reset empties all levels, marks no slot as running,
// clears the last tick time and loads the quantum; the link RAM is not cleared.
// ----------------------------------------------------------------------------
module priority_run_queue_dispatcher_top #(
    parameter int SLOT_COUNT  = prqd_pkg::SLOT_COUNT_DEF,
    parameter int LEVEL_COUNT = prqd_pkg::LEVEL_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  prqd_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output prqd_pkg::t_res o_out_res,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int LW = $clog2(LEVEL_COUNT);
    localparam int LINK_W = SW + 1;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_ENQ_LINK  = 4'd2;
    localparam logic [3:0] S_ENQ_CLR   = 4'd3;
    localparam logic [3:0] S_TICK_CMP  = 4'd4;
    localparam logic [3:0] S_DISP_SEL  = 4'd5;
    localparam logic [3:0] S_DISP_READ = 4'd6;
    localparam logic [3:0] S_DISP_UPD  = 4'd7;
    localparam logic [3:0] S_DISP_CMP  = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    logic [3:0]     r_state;
    logic [3:0]     n_state;
    prqd_pkg::t_req r_req;
    prqd_pkg::t_res r_res;
    prqd_pkg::t_res r_out;
    logic           r_out_valid;
    logic [15:0]    r_quantum;
    logic [31:0]    r_last;
    logic [31:0]    r_acc;
    logic           r_run_vld;
    logic [SW-1:0]  r_run_slot;
    logic [SW-1:0]  r_slot;
    logic [LW-1:0]  r_lvl;

    logic           r_head_vld  [LEVEL_COUNT];
    logic [SW-1:0]  r_head_slot [LEVEL_COUNT];
    logic           r_tail_vld  [LEVEL_COUNT];
    logic [SW-1:0]  r_tail_slot [LEVEL_COUNT];

    logic [31:0]    slot_wide;
    logic [31:0]    prio_wide;
    logic [31:0]    lvl_wide;
    logic [31:0]    chosen_wide;
    logic [SW-1:0]  slot_idx;
    logic [LW-1:0]  enq_lvl;
    logic           bad_req;
    logic           any_ready;
    logic [LW-1:0]  sel_lvl;
    logic           out_free;

    logic [31:0]    alu_a;
    logic [31:0]    alu_b;
    logic [31:0]    alu_diff;
    logic           alu_borrow;
    logic           alu_zero;

    logic              ram_we;
    logic [SW-1:0]     ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [SW-1:0]     ram_raddr;
    logic [LINK_W-1:0] ram_rdata;

    assign slot_wide   = 32'(r_req.slot);
    assign prio_wide   = 32'(r_req.prio_level);
    assign lvl_wide    = prio_wide - 32'd1;
    assign chosen_wide = 32'(r_slot);
    assign slot_idx    = slot_wide[SW-1:0];
    assign enq_lvl     = lvl_wide[LW-1:0];
    assign bad_req     = (prio_wide == 32'd0) || (prio_wide > LEVEL_COUNT)
                         || (slot_wide >= SLOT_COUNT);
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        any_ready = 1'b0;
        sel_lvl   = '0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            if (r_head_vld[i]) begin
                any_ready = 1'b1;
                sel_lvl   = LW'(i);
            end
        end
    end

    always_comb begin
        unique case (r_state)
            S_DECODE: begin
                alu_a = r_req.clock_time;
                alu_b = r_last;
            end
            S_TICK_CMP: begin
                alu_a = r_acc;
                alu_b = 32'(r_quantum);
            end
            S_DISP_CMP: begin
                alu_a = 32'(r_run_slot);
                alu_b = 32'(r_slot);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    prqd_alu u_alu (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_diff   (alu_diff),
        .o_borrow (alu_borrow),
        .o_zero   (alu_zero)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_idx;
        ram_wdata = '0;
        unique case (r_state)
            S_ENQ_LINK: begin
                ram_we    = r_head_vld[r_lvl] && r_tail_vld[r_lvl];
                ram_waddr = r_tail_slot[r_lvl];
                ram_wdata = {1'b1, slot_idx};
            end
            S_ENQ_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = slot_idx;
            end
            S_DISP_UPD: begin
                ram_we    = 1'b1;
                ram_waddr = r_slot;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_raddr = r_head_slot[r_lvl];

    prqd_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOT_COUNT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_req.cmd != prqd_pkg::CMD_UNUSED) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_req.cmd)
                    prqd_pkg::CMD_ENQUEUE:  n_state = bad_req ? S_DONE : S_ENQ_LINK;
                    prqd_pkg::CMD_DISPATCH: n_state = S_DISP_SEL;
                    default:                n_state = S_TICK_CMP;
                endcase
            end
            S_ENQ_LINK:  n_state = S_ENQ_CLR;
            S_ENQ_CLR:   n_state = S_DONE;
            S_TICK_CMP:  n_state = alu_borrow ? S_DONE : S_DISP_SEL;
            S_DISP_SEL:  n_state = any_ready ? S_DISP_READ : S_DONE;
            S_DISP_READ: n_state = S_DISP_UPD;
            S_DISP_UPD:  n_state = S_DISP_CMP;
            S_DISP_CMP:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_quantum   <= prqd_pkg::QUANTUM_RESET;
            r_last      <= '0;
            r_run_vld   <= 1'b0;
            for (int i = 0; i < LEVEL_COUNT; i++) begin
                r_head_vld[i] <= 1'b0;
                r_tail_vld[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_ENQ_LINK: begin
                    r_head_vld[r_lvl] <= 1'b1;
                    r_tail_vld[r_lvl] <= 1'b1;
                end
                S_TICK_CMP: begin
                    if (!alu_borrow) begin
                        r_last <= r_req.clock_time;
                    end
                end
                S_DISP_UPD: begin
                    r_head_vld[r_lvl] <= ram_rdata[LINK_W-1];
                    if (!ram_rdata[LINK_W-1]) begin
                        r_tail_vld[r_lvl] <= 1'b0;
                    end
                end
                S_DISP_CMP: begin
                    r_run_vld <= 1'b1;
                end
                default: begin
                    r_run_vld <= r_run_vld;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_req;
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
        unique case (r_state)
            S_DECODE: begin
                r_acc <= alu_diff;
                r_lvl <= enq_lvl;
                r_res <= '{status: prqd_pkg::STAT_BAD_PRIO, chosen_slot: '0,
                           switched: 1'b0};
            end
            S_ENQ_LINK: begin
                if (!r_head_vld[r_lvl]) begin
                    r_head_slot[r_lvl] <= slot_idx;
                end
                r_tail_slot[r_lvl] <= slot_idx;
            end
            S_ENQ_CLR: begin
                r_res <= '{status: prqd_pkg::STAT_ENQUEUED, chosen_slot: '0,
                           switched: 1'b0};
            end
            S_TICK_CMP: begin
                r_res <= '{status: prqd_pkg::STAT_TOO_EARLY, chosen_slot: '0,
                           switched: 1'b0};
            end
            S_DISP_SEL: begin
                r_lvl <= sel_lvl;
                r_res <= '{status: prqd_pkg::STAT_NONE_READY, chosen_slot: '0,
                           switched: 1'b0};
            end
            S_DISP_READ: begin
                r_slot <= r_head_slot[r_lvl];
            end
            S_DISP_UPD: begin
                r_head_slot[r_lvl] <= ram_rdata[SW-1:0];
            end
            S_DISP_CMP: begin
                r_run_slot <= r_slot;
                r_res <= '{status: prqd_pkg::STAT_DISPATCHED,
                           chosen_slot: chosen_wide[5:0],
                           switched: !r_run_vld || !alu_zero};
            end
            default: begin
                r_lvl <= r_lvl;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

// ===== rtl/prqd_checker.sv =====
// ----------------------------------------------------------------------------
// Run queue dispatcher port checker
// Concurrent checks on the request and response ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_run_queue_dispatcher_top_macros.svh"

module prqd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input prqd_pkg::t_req i_in_req,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input prqd_pkg::t_res o_out_res
);

    `PRQD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_res))
    `PRQD_ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_out_valid, o_out_res.status <= prqd_pkg::STAT_TOO_EARLY)
    `PRQD_ASSERT_SAME(a_idle_fields, i_clk, i_rst_n, o_out_valid && o_out_res.status != prqd_pkg::STAT_DISPATCHED, o_out_res.chosen_slot == 6'd0 && !o_out_res.switched)
    `PRQD_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_req.cmd != prqd_pkg::CMD_UNUSED, !o_in_ready)

endmodule

bind priority_run_queue_dispatcher_top prqd_checker u_prqd_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Run queue dispatcher testbench
// Walks a table of directed requests and then six random phases.
// Each phase sets its quantum and the idle pattern on both channels.
// Every accepted request also runs through a local scheduler model, and each
// response is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module tb;

    localparam int LEVELS       = prqd_pkg::LEVEL_COUNT_DEF;
    localparam int SLOTS        = prqd_pkg::SLOT_COUNT_DEF;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 250000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_PHASE   = 4;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 150;
    localparam int Q_RANDOM     = -1;

    localparam int PHASE_QUANTUM [PHASES] = '{0, 65535, Q_RANDOM,
                                              int'(prqd_pkg::QUANTUM_RESET), Q_RANDOM, 1};
    localparam int PHASE_SEND_IDLE [PHASES] = '{9, 9, 52, 52, 0, 0};
    localparam int PHASE_RECV_IDLE [PHASES] = '{52, 52, 9, 9, 0, 0};

    typedef struct packed {
        prqd_pkg::t_req req;
        logic           typed;
        prqd_pkg::t_res res;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 23;

    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{'{prqd_pkg::CMD_TICK, 6'd0, 3'd0, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_TOO_EARLY, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_DISPATCH, 6'd0, 3'd0, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_NONE_READY, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_TICK, 6'd0, 3'd0, 32'hFFFF_FFFF}, 1'b1,
          '{prqd_pkg::STAT_NONE_READY, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_TICK, 6'd0, 3'd0, 32'h0000_004E}, 1'b1,
          '{prqd_pkg::STAT_TOO_EARLY, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_TICK, 6'd0, 3'd0, 32'h0000_004F}, 1'b1,
          '{prqd_pkg::STAT_NONE_READY, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_ENQUEUE, 6'd63, 3'd0, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_BAD_PRIO, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_ENQUEUE, 6'd63, 3'd7, 32'hFFFF_FFFF}, 1'b1,
          '{prqd_pkg::STAT_BAD_PRIO, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_ENQUEUE, 6'd63, 3'd1, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_ENQUEUE, 6'd0, 3'd6, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_ENQUEUE, 6'd21, 3'd6, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_ENQUEUE, 6'd42, 3'd3, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_UNUSED, 6'd42, 3'd5, 32'hAAAA_5555}, 1'b0,
          '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_DISPATCH, 6'd0, 3'd0, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_DISPATCHED, 6'd63, 1'b1}},
        '{'{prqd_pkg::CMD_ENQUEUE, 6'd63, 3'd1, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_DISPATCH, 6'd0, 3'd0, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_DISPATCHED, 6'd63, 1'b0}},
        '{'{prqd_pkg::CMD_TICK, 6'd0, 3'd0, 32'h0000_009E}, 1'b1,
          '{prqd_pkg::STAT_TOO_EARLY, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_TICK, 6'd0, 3'd0, 32'h0000_009F}, 1'b1,
          '{prqd_pkg::STAT_DISPATCHED, 6'd42, 1'b1}},
        '{'{prqd_pkg::CMD_DISPATCH, 6'd0, 3'd0, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_DISPATCHED, 6'd0, 1'b1}},
        '{'{prqd_pkg::CMD_ENQUEUE, 6'd0, 3'd6, 32'h0000_0000}, 1'b1,
          '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_ENQUEUE, 6'd21, 3'd2, 32'h0000_0000}, 1'b0,
          '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_DISPATCH, 6'd0, 3'd0, 32'h0000_0000}, 1'b0,
          '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_DISPATCH, 6'd0, 3'd0, 32'h0000_0000}, 1'b0,
          '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0}},
        '{'{prqd_pkg::CMD_DISPATCH, 6'd0, 3'd0, 32'h0000_0000}, 1'b0,
          '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0}}
    };

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_ready;
    prqd_pkg::t_req i_in_req    = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    prqd_pkg::t_res o_out_res;
    logic           i_cfg_we    = 1'b0;
    logic [15:0]    i_cfg_wdata = '0;

    // Scheduler model state.
    logic        head_ok   [LEVELS] = '{default: 1'b0};
    logic [5:0]  head_slot [LEVELS] = '{default: 6'd0};
    logic        tail_ok   [LEVELS] = '{default: 1'b0};
    logic [5:0]  tail_slot [LEVELS] = '{default: 6'd0};
    logic        link_ok   [SLOTS]  = '{default: 1'b0};
    logic [5:0]  link_slot [SLOTS]  = '{default: 6'd0};
    logic        slot_queued [SLOTS] = '{default: 1'b0};
    logic        run_ok    = 1'b0;
    logic [5:0]  run_slot  = 6'd0;
    logic [31:0] last_tick = 32'd0;
    logic [15:0] cur_quantum = prqd_pkg::QUANTUM_RESET;

    prqd_pkg::t_res due_results [$];
    prqd_pkg::t_res want_res;
    int   error_count   = 0;
    int   cycle_count   = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_req      = 0;
    int   hold_left     = 0;

    priority_run_queue_dispatcher_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic prqd_pkg::t_res dispatch_head();
        prqd_pkg::t_res r;
        logic [5:0]     s;
        bit             found;
        r     = '{prqd_pkg::STAT_NONE_READY, 6'd0, 1'b0};
        found = 1'b0;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            if (head_ok[lvl] && !found) begin
                found          = 1'b1;
                s              = head_slot[lvl];
                head_ok[lvl]   = link_ok[s];
                head_slot[lvl] = link_slot[s];
                if (!head_ok[lvl]) begin
                    tail_ok[lvl] = 1'b0;
                end
                link_ok[s]     = 1'b0;
                link_slot[s]   = 6'd0;
                slot_queued[s] = 1'b0;
                r.status       = prqd_pkg::STAT_DISPATCHED;
                r.chosen_slot  = s;
                r.switched     = !run_ok || (run_slot != s);
                run_ok         = 1'b1;
                run_slot       = s;
            end
        end
        return r;
    endfunction

    function automatic bit sched_step(input prqd_pkg::t_req q, output prqd_pkg::t_res r);
        int          lvl;
        logic [31:0] elapsed;
        r = '{prqd_pkg::STAT_ENQUEUED, 6'd0, 1'b0};
        case (q.cmd)
            prqd_pkg::CMD_ENQUEUE: begin
                if (q.prio_level < 3'd1 || q.prio_level > 3'(LEVELS)) begin
                    r.status = prqd_pkg::STAT_BAD_PRIO;
                end else begin
                    lvl = int'(q.prio_level) - 1;
                    if (!head_ok[lvl]) begin
                        head_ok[lvl]   = 1'b1;
                        head_slot[lvl] = q.slot;
                    end else if (tail_ok[lvl]) begin
                        link_ok[tail_slot[lvl]]   = 1'b1;
                        link_slot[tail_slot[lvl]] = q.slot;
                    end
                    tail_ok[lvl]        = 1'b1;
                    tail_slot[lvl]      = q.slot;
                    link_ok[q.slot]     = 1'b0;
                    link_slot[q.slot]   = 6'd0;
                    slot_queued[q.slot] = 1'b1;
                end
                return 1'b1;
            end
            prqd_pkg::CMD_DISPATCH: begin
                r = dispatch_head();
                return 1'b1;
            end
            prqd_pkg::CMD_TICK: begin
                elapsed = q.clock_time - last_tick;
                if (elapsed >= {16'd0, cur_quantum}) begin
                    last_tick = q.clock_time;
                    r = dispatch_head();
                end else begin
                    r.status = prqd_pkg::STAT_TOO_EARLY;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: response mismatch on %s, got %0h, expected %0h", $time, what, got,
                 want);
        error_count++;
    endtask

    task automatic offer_request(input prqd_pkg::t_req q, input bit typed,
                                 input prqd_pkg::t_res typed_res);
        prqd_pkg::t_res predicted;
        bit             gives;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= q;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        gives = sched_step(q, predicted);
        if (gives) begin
            due_results.push_back(typed ? typed_res : predicted);
        end
    endtask

    task automatic write_quantum(input logic [15:0] value);
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_quantum = value;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected response", 32'(o_out_res), 32'd0);
            end else begin
                want_res = due_results.pop_front();
                if (o_out_res.status !== want_res.status) begin
                    report_mismatch("status", 32'(o_out_res.status), 32'(want_res.status));
                end
                if (o_out_res.chosen_slot !== want_res.chosen_slot) begin
                    report_mismatch("chosen_slot", 32'(o_out_res.chosen_slot),
                                    32'(want_res.chosen_slot));
                end
                if (o_out_res.switched !== want_res.switched) begin
                    report_mismatch("switched", 32'(o_out_res.switched),
                                    32'(want_res.switched));
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("priority_run_queue_dispatcher_top verification failed");
        $finish;
    end

    initial begin
        prqd_pkg::t_req q;
        int             pick;
        int             sent;
        logic [15:0]    quantum;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = PHASE_SEND_IDLE[0];
        recv_idle_pct = PHASE_RECV_IDLE[0];
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            offer_request(DIRECTED[row].req, DIRECTED[row].typed, DIRECTED[row].res);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (PHASE_QUANTUM[ph] == Q_RANDOM) begin
                quantum = 16'($urandom_range(1, 400));
            end else begin
                quantum = 16'(PHASE_QUANTUM[ph]);
            end
            write_quantum(quantum);
            send_idle_pct = PHASE_SEND_IDLE[ph];
            recv_idle_pct = PHASE_RECV_IDLE[ph];
            if (ph == HOLD_PHASE) begin
                hold_req = HOLD_CYCLES;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                q.clock_time = $urandom();
                q.slot       = 6'($urandom_range(SLOTS - 1));
                q.prio_level = 3'($urandom_range(1, LEVELS));
                pick         = $urandom_range(99);
                if (pick < 45) begin
                    q.cmd = prqd_pkg::CMD_ENQUEUE;
                    // Mostly pick a slot that is not already waiting in a level.
                    if (pick < 35) begin
                        repeat (4) begin
                            if (slot_queued[q.slot]) begin
                                q.slot = 6'($urandom_range(SLOTS - 1));
                            end
                        end
                    end
                end else if (pick < 67) begin
                    q.cmd = prqd_pkg::CMD_DISPATCH;
                end else if (pick < 94) begin
                    q.cmd = prqd_pkg::CMD_TICK;
                    case ($urandom_range(7))
                        0: q.clock_time = $urandom();
                        1: q.clock_time = last_tick + 32'(cur_quantum) - 32'd1;
                        2: q.clock_time = last_tick + 32'(cur_quantum);
                        default: begin
                            q.clock_time = last_tick
                                + 32'($urandom_range(0, 2 * cur_quantum + 4));
                        end
                    endcase
                end else if (pick < 97) begin
                    q.cmd        = prqd_pkg::CMD_ENQUEUE;
                    q.prio_level = $urandom_range(1) ? 3'd0 : 3'd7;
                end else begin
                    q.cmd = prqd_pkg::CMD_UNUSED;
                end
                offer_request(q, 1'b0, '0);
                if (q.cmd != prqd_pkg::CMD_UNUSED) begin
                    sent++;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("priority_run_queue_dispatcher_top verification clean");
        end else begin
            $display("priority_run_queue_dispatcher_top verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/prqd_pkg.sv
rtl/prqd_ram.sv
rtl/prqd_alu.sv
rtl/priority_run_queue_dispatcher_top.sv
rtl/prqd_checker.sv
bench/tb.sv
